// ===== hdl/cpt_pkg.sv =====
// Package for the close peer table: payload structs, kinds, outcomes and states.
`timescale 1ns / 1ps
package cpt_pkg;

    localparam int unsigned KEY_BITS = 256;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_EVICT = 2'd2,
        KIND_LIST  = 2'd3
    } kind_t;

    localparam logic [1:0] OUT_OK       = 2'd0;
    localparam logic [1:0] OUT_ALT      = 2'd1;
    localparam logic [1:0] OUT_REPLACED = 2'd2;
    localparam logic [1:0] OUT_REJECTED = 2'd3;

    localparam logic [2:0] CFG_KEY_W0  = 3'd0;
    localparam logic [2:0] CFG_KEY_W1  = 3'd1;
    localparam logic [2:0] CFG_KEY_W2  = 3'd2;
    localparam logic [2:0] CFG_KEY_W3  = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT = 3'd4;

    localparam logic [7:0] TIMEOUT_RESET = 8'd30;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] peer_id_w0;
        logic [63:0] peer_id_w1;
        logic [63:0] peer_id_w2;
        logic [63:0] peer_id_w3;
        logic [63:0] peer_addr_hi;
        logic [63:0] peer_addr_lo;
        logic [15:0] peer_port;
        logic [31:0] now_seconds;
    } req_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [2:0]  slot_index;
        logic [3:0]  closer_count;
        logic [63:0] entry_id_w0;
        logic [63:0] entry_id_w1;
        logic [63:0] entry_id_w2;
        logic [63:0] entry_id_w3;
        logic [63:0] entry_addr_hi;
        logic [63:0] entry_addr_lo;
        logic [15:0] entry_port;
        logic        last_of_run;
    } rsp_t;

    // Phases: P1 match scan, P2 stale scan, P3 closer scan.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_CMP,
        ST_EMIT,
        ST_LIST,
        ST_WAIT
    } state_t;

endpackage

// ===== hdl/close_peer_table_core.sv =====
// Close peer table: slot storage, shared id compare unit and scan sequencer.
`timescale 1ns / 1ps
// Usage:
// Requests enter on req/req_valid/req_stall; req_stall is high while a request
// is being worked, so one request is handled at a time. Results leave on
// rsp/rsp_valid and are held while rsp_stall is high; last_of_run marks the
// final result of a request. Registers are written on cfg_valid/cfg_ready
// (index 0..3 own key words, 4 stale timeout) while the block is idle.
// Timing: every request scans the slots one per cycle through one shared
// 256-bit equality/closeness unit, evaluated combinationally on the current
// slot. A setup state follows acceptance; add then scans for a match, a stale
// slot and a closer entry, in that order, and loads its result; query and
// evict make only the match scan. List first marks the live slots, then walks
// the slots one per cycle, giving one entry per cycle while the receiver
// takes them. The next request is accepted in the cycle after the last result
// is taken.
// A stalled result holds the sequencer; nothing is lost.
// Reset: all slots cleared to zero, own key zero, timeout 30, idle.
module close_peer_table_core #(
    parameter int TABLE_SLOTS = 8,
    parameter int ID_BYTES    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cpt_pkg::req_t       req,
    input  logic                req_valid,
    output logic                req_stall,
    output cpt_pkg::rsp_t       rsp,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                cfg_valid,
    output logic                cfg_ready
);

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    logic [255:0] id_mem [TABLE_SLOTS];
    logic [127:0] addr_mem [TABLE_SLOTS];
    logic [15:0]  port_mem [TABLE_SLOTS];
    logic [31:0]  seen_mem [TABLE_SLOTS];

    logic [255:0] key_reg;
    logic [7:0]   timeout_reg;

    cpt_pkg::state_t state_reg, state_next;
    cpt_pkg::req_t   req_reg;
    cpt_pkg::rsp_t   rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            listed_reg, listed_next;

    // live slots of a list request, marked before the walk
    logic [TABLE_SLOTS-1:0] live_reg, live_next;
    logic                   more_live;

    logic [255:0] cand_id;
    logic [255:0] held_id;
    logic         eq_c, closer_c, stale_c, key_eq_c;
    logic         last_slot;

    assign cand_id = {req_reg.peer_id_w0, req_reg.peer_id_w1,
                      req_reg.peer_id_w2, req_reg.peer_id_w3};
    assign held_id = id_mem[slot_reg];
    assign last_slot = (slot_reg == SW'(TABLE_SLOTS - 1));

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0] d;
        d = $signed({a[7], a}) - $signed({b[7], b});
        abs_diff = d[8] ? 8'(-d) : d[7:0];
    endfunction

    // shared compare unit: equality and closeness over the first ID_BYTES
    always_comb
    begin
        logic [7:0] kb, hb, cb, d1, d2;
        logic       decided;
        eq_c = 1'b1;
        key_eq_c = 1'b1;
        closer_c = 1'b0;
        decided = 1'b0;
        for (int i = 0; i < ID_BYTES; i++)
        begin
            kb = key_reg[255 - 8*i -: 8];
            hb = held_id[255 - 8*i -: 8];
            cb = cand_id[255 - 8*i -: 8];
            if (hb != cb)
                eq_c = 1'b0;
            if (kb != cb)
                key_eq_c = 1'b0;
            d1 = abs_diff(kb, hb);
            d2 = abs_diff(kb, cb);
            if (!decided && d1 != d2)
            begin
                decided = 1'b1;
                closer_c = (d1 > d2);
            end
        end
        stale_c = ({1'b0, seen_mem[slot_reg]} + 33'(timeout_reg))
                  <= {1'b0, req_reg.now_seconds};
    end

    // any live slot above the current one decides last_of_run of a listed entry
    always_comb
    begin
        more_live = 1'b0;
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (SW'(i) > slot_reg && live_reg[i])
                more_live = 1'b1;
    end

    assign req_stall = (state_reg != cpt_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == cpt_pkg::ST_IDLE);
    assign rsp = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cpt_pkg::ST_IDLE:
                if (req_valid)
                    state_next = cpt_pkg::ST_CMP;
            cpt_pkg::ST_CMP:
                if (req_reg.kind != cpt_pkg::KIND_LIST)
                    state_next = cpt_pkg::ST_P1;
                else if (last_slot)
                    state_next = cpt_pkg::ST_LIST;
            cpt_pkg::ST_P1:
                if (req_reg.kind == cpt_pkg::KIND_QUERY)
                begin
                    if (key_eq_c || (!stale_c && eq_c) || last_slot)
                        state_next = cpt_pkg::ST_EMIT;
                end
                else if (eq_c)
                    state_next = cpt_pkg::ST_EMIT;
                else if (last_slot)
                    state_next = (req_reg.kind == cpt_pkg::KIND_ADD) ? cpt_pkg::ST_P2
                               : cpt_pkg::ST_EMIT;
            cpt_pkg::ST_P2:
                if (stale_c)
                    state_next = cpt_pkg::ST_EMIT;
                else if (last_slot)
                    state_next = cpt_pkg::ST_P3;
            cpt_pkg::ST_P3:
                if (closer_c || last_slot)
                    state_next = cpt_pkg::ST_EMIT;
            cpt_pkg::ST_EMIT:
                state_next = cpt_pkg::ST_WAIT;
            cpt_pkg::ST_LIST:
                if (live_reg[slot_reg] && rsp_valid_reg && rsp_stall)
                    state_next = cpt_pkg::ST_LIST;
                else if (last_slot)
                    state_next = cpt_pkg::ST_WAIT;
            cpt_pkg::ST_WAIT:
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = cpt_pkg::ST_IDLE;
            default:
                state_next = cpt_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        slot_next = slot_reg;
        cnt_next = cnt_reg;
        listed_next = listed_reg;
        live_next = live_reg;
        case (state_reg)
            cpt_pkg::ST_IDLE:
            begin
                slot_next = '0;
                cnt_next = '0;
                listed_next = 1'b0;
                live_next = '0;
                rsp_next = '0;
                rsp_next.last_of_run = 1'b1;
            end
            cpt_pkg::ST_CMP:
            begin
                if (req_reg.kind == cpt_pkg::KIND_LIST)
                begin
                    live_next[slot_reg] = !stale_c;
                    slot_next = last_slot ? '0 : slot_reg + SW'(1);
                end
            end
            cpt_pkg::ST_P1:
            begin
                if (req_reg.kind == cpt_pkg::KIND_QUERY)
                begin
                    if (key_eq_c || (!stale_c && eq_c))
                        rsp_next.outcome = cpt_pkg::OUT_ALT;
                    else if ((stale_c || closer_c) && cnt_reg != CW'(15))
                        cnt_next = cnt_reg + CW'(1);
                end
                else if (eq_c)
                begin
                    rsp_next.outcome = cpt_pkg::OUT_OK;
                    rsp_next.slot_index = 3'(slot_reg);
                end
                else if (last_slot)
                begin
                    if (req_reg.kind == cpt_pkg::KIND_EVICT)
                        rsp_next.outcome = cpt_pkg::OUT_ALT;
                end
                if (!last_slot)
                    slot_next = slot_reg + SW'(1);
                else
                    slot_next = '0;
                if (eq_c && req_reg.kind != cpt_pkg::KIND_QUERY)
                    slot_next = slot_reg;
            end
            cpt_pkg::ST_P2:
            begin
                if (stale_c)
                begin
                    rsp_next.outcome = cpt_pkg::OUT_ALT;
                    rsp_next.slot_index = 3'(slot_reg);
                end
                else
                    slot_next = last_slot ? '0 : slot_reg + SW'(1);
            end
            cpt_pkg::ST_P3:
            begin
                if (closer_c)
                begin
                    rsp_next.outcome = cpt_pkg::OUT_REPLACED;
                    rsp_next.slot_index = 3'(slot_reg);
                end
                else if (last_slot)
                    rsp_next.outcome = cpt_pkg::OUT_REJECTED;
                else
                    slot_next = slot_reg + SW'(1);
            end
            cpt_pkg::ST_EMIT:
            begin
                rsp_valid_next = 1'b1;
                if (req_reg.kind == cpt_pkg::KIND_QUERY && rsp_reg.outcome == cpt_pkg::OUT_OK)
                    rsp_next.closer_count = (cnt_reg > CW'(15)) ? 4'd15 : 4'(cnt_reg);
            end
            cpt_pkg::ST_LIST:
            begin
                if (live_reg[slot_reg])
                begin
                    if (!(rsp_valid_reg && rsp_stall))
                    begin
                        rsp_valid_next = 1'b1;
                        listed_next = 1'b1;
                        rsp_next.outcome = cpt_pkg::OUT_OK;
                        rsp_next.slot_index = 3'(slot_reg);
                        rsp_next.closer_count = '0;
                        {rsp_next.entry_id_w0, rsp_next.entry_id_w1,
                         rsp_next.entry_id_w2, rsp_next.entry_id_w3} = id_mem[slot_reg];
                        {rsp_next.entry_addr_hi, rsp_next.entry_addr_lo} = addr_mem[slot_reg];
                        rsp_next.entry_port = port_mem[slot_reg];
                        rsp_next.last_of_run = !more_live;
                        slot_next = slot_reg + SW'(1);
                    end
                end
                else
                    slot_next = slot_reg + SW'(1);
                if (last_slot && !live_reg[slot_reg])
                begin
                    if (!listed_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next = '0;
                        rsp_next.outcome = cpt_pkg::OUT_ALT;
                        rsp_next.last_of_run = 1'b1;
                    end
                    else
                        listed_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer and handshake registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpt_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            slot_reg <= '0;
            cnt_reg <= '0;
            listed_reg <= 1'b0;
            live_reg <= '0;
            key_reg <= '0;
            timeout_reg <= cpt_pkg::TIMEOUT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            slot_reg <= slot_next;
            cnt_reg <= cnt_next;
            listed_reg <= listed_next;
            live_reg <= live_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cpt_pkg::CFG_KEY_W0:  key_reg[255:192] <= cfg_data;
                    cpt_pkg::CFG_KEY_W1:  key_reg[191:128] <= cfg_data;
                    cpt_pkg::CFG_KEY_W2:  key_reg[127:64]  <= cfg_data;
                    cpt_pkg::CFG_KEY_W3:  key_reg[63:0]    <= cfg_data;
                    cpt_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (state_reg == cpt_pkg::ST_IDLE && req_valid)
            req_reg <= req;
    end

    // slot storage; reset clears every slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TABLE_SLOTS; s++)
            begin
                id_mem[s] <= '0;
                addr_mem[s] <= '0;
                port_mem[s] <= '0;
                seen_mem[s] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                cpt_pkg::ST_P1:
                    if (eq_c && req_reg.kind == cpt_pkg::KIND_ADD)
                        seen_mem[slot_reg] <= req_reg.now_seconds;
                    else if (eq_c && req_reg.kind == cpt_pkg::KIND_EVICT)
                        seen_mem[slot_reg] <= '0;
                cpt_pkg::ST_P2, cpt_pkg::ST_P3:
                    if ((state_reg == cpt_pkg::ST_P2) ? stale_c : closer_c)
                    begin
                        id_mem[slot_reg] <= cand_id;
                        addr_mem[slot_reg] <= {req_reg.peer_addr_hi, req_reg.peer_addr_lo};
                        port_mem[slot_reg] <= req_reg.peer_port;
                        seen_mem[slot_reg] <= req_reg.now_seconds;
                    end
                default: ;
            endcase
        end
    end

    // a finished result appears only after the scan that produced it
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpt_pkg::ST_EMIT) |=> rsp_valid)
        else $error("emit without result");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("accepted request not held busy");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

endmodule

// ===== bench/cpt_checker.sv =====
// Checker for the close peer table: watches both channels, predicts results, compares.
`timescale 1ns / 1ps
module cpt_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  cpt_pkg::req_t   req,
    input  logic            req_valid,
    input  logic            req_stall,
    input  cpt_pkg::rsp_t   rsp,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_data,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    output int              fail_count,
    output int              pending
);
    localparam int SLOTS = 8;

    logic [255:0]  own_key;
    logic [7:0]    timeout;
    logic [255:0]  tbl_id [SLOTS];
    logic [127:0]  tbl_addr [SLOTS];
    logic [15:0]   tbl_port [SLOTS];
    logic [31:0]   tbl_seen [SLOTS];
    cpt_pkg::rsp_t expected_rsp [$];

    assign pending = expected_rsp.size();

    function automatic bit slot_stale(int s, logic [31:0] now);
        return ({1'b0, tbl_seen[s]} + 33'(timeout)) <= {1'b0, now};
    endfunction

    function automatic int byte_dist(logic [7:0] a, logic [7:0] b);
        int d;
        d = $signed(a) - $signed(b);
        return d < 0 ? -d : d;
    endfunction

    // byte 0 is the most significant byte of word 0
    function automatic bit closer_than(logic [255:0] held, logic [255:0] cand);
        int d1, d2;
        for (int i = 0; i < 32; i++)
        begin
            d1 = byte_dist(own_key[255-8*i -: 8], held[255-8*i -: 8]);
            d2 = byte_dist(own_key[255-8*i -: 8], cand[255-8*i -: 8]);
            if (d1 < d2) return 0;
            if (d1 > d2) return 1;
        end
        return 0;
    endfunction

    task automatic predict_request(cpt_pkg::req_t r);
        logic [255:0] id;
        cpt_pkg::rsp_t res;
        int cnt;
        int listed;
        bit done;
        id = {r.peer_id_w0, r.peer_id_w1, r.peer_id_w2, r.peer_id_w3};
        res = '0;
        res.last_of_run = 1'b1;
        done = 0;
        cnt = 0;
        listed = 0;
        case (cpt_pkg::kind_t'(r.kind))
            cpt_pkg::KIND_ADD:
            begin
                for (int s = 0; s < SLOTS && !done; s++)
                    if (tbl_id[s] == id)
                    begin
                        tbl_seen[s] = r.now_seconds;
                        res.outcome = cpt_pkg::OUT_OK;
                        res.slot_index = 3'(s);
                        done = 1;
                    end
                for (int s = 0; s < SLOTS && !done; s++)
                    if (slot_stale(s, r.now_seconds))
                    begin
                        res.outcome = cpt_pkg::OUT_ALT;
                        res.slot_index = 3'(s);
                        done = 1;
                    end
                for (int s = 0; s < SLOTS && !done; s++)
                    if (closer_than(tbl_id[s], id))
                    begin
                        res.outcome = cpt_pkg::OUT_REPLACED;
                        res.slot_index = 3'(s);
                        done = 1;
                    end
                if (!done)
                    res.outcome = cpt_pkg::OUT_REJECTED;
                else if (res.outcome != cpt_pkg::OUT_OK)
                begin
                    tbl_id[res.slot_index] = id;
                    tbl_addr[res.slot_index] = {r.peer_addr_hi, r.peer_addr_lo};
                    tbl_port[res.slot_index] = r.peer_port;
                    tbl_seen[res.slot_index] = r.now_seconds;
                end
                expected_rsp.push_back(res);
            end
            cpt_pkg::KIND_QUERY:
            begin
                if (own_key == id)
                begin
                    res.outcome = cpt_pkg::OUT_ALT;
                    done = 1;
                end
                for (int s = 0; s < SLOTS && !done; s++)
                begin
                    if (slot_stale(s, r.now_seconds))
                        cnt++;
                    else if (tbl_id[s] == id)
                    begin
                        res.outcome = cpt_pkg::OUT_ALT;
                        done = 1;
                    end
                    else if (closer_than(tbl_id[s], id))
                        cnt++;
                end
                if (!done)
                    res.closer_count = 4'(cnt > 15 ? 15 : cnt);
                expected_rsp.push_back(res);
            end
            cpt_pkg::KIND_EVICT:
            begin
                res.outcome = cpt_pkg::OUT_ALT;
                for (int s = 0; s < SLOTS && !done; s++)
                    if (tbl_id[s] == id)
                    begin
                        tbl_seen[s] = '0;
                        res.outcome = cpt_pkg::OUT_OK;
                        res.slot_index = 3'(s);
                        done = 1;
                    end
                expected_rsp.push_back(res);
            end
            default:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (!slot_stale(s, r.now_seconds))
                    begin
                        if (listed > 0)
                            expected_rsp.push_back(res);
                        res = '0;
                        res.slot_index = 3'(s);
                        {res.entry_id_w0, res.entry_id_w1,
                         res.entry_id_w2, res.entry_id_w3} = tbl_id[s];
                        {res.entry_addr_hi, res.entry_addr_lo} = tbl_addr[s];
                        res.entry_port = tbl_port[s];
                        listed++;
                    end
                if (listed == 0)
                    res.outcome = cpt_pkg::OUT_ALT;
                res.last_of_run = 1'b1;
                expected_rsp.push_back(res);
            end
        endcase
    endtask

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_result(cpt_pkg::rsp_t got);
        cpt_pkg::rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            $error("result with nothing expected: %p", got);
            fail_count++;
            return;
        end
        want = expected_rsp.pop_front();
        compare_field("outcome", 64'(want.outcome), 64'(got.outcome));
        compare_field("slot_index", 64'(want.slot_index), 64'(got.slot_index));
        compare_field("closer_count", 64'(want.closer_count), 64'(got.closer_count));
        compare_field("entry_id_w0", want.entry_id_w0, got.entry_id_w0);
        compare_field("entry_id_w1", want.entry_id_w1, got.entry_id_w1);
        compare_field("entry_id_w2", want.entry_id_w2, got.entry_id_w2);
        compare_field("entry_id_w3", want.entry_id_w3, got.entry_id_w3);
        compare_field("entry_addr_hi", want.entry_addr_hi, got.entry_addr_hi);
        compare_field("entry_addr_lo", want.entry_addr_lo, got.entry_addr_lo);
        compare_field("entry_port", 64'(want.entry_port), 64'(got.entry_port));
        compare_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_key <= '0;
            timeout <= cpt_pkg::TIMEOUT_RESET;
            for (int s = 0; s < SLOTS; s++)
            begin
                tbl_id[s] <= '0;
                tbl_addr[s] <= '0;
                tbl_port[s] <= '0;
                tbl_seen[s] <= '0;
            end
            fail_count <= 0;
        end
        else
        begin
            // result side first: a request accepted now cannot answer in the same edge
            if (rsp_valid && !rsp_stall)
                check_result(rsp);
            if (req_valid && !req_stall)
                predict_request(req);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cpt_pkg::CFG_KEY_W0: own_key[255:192] = cfg_data;
                    cpt_pkg::CFG_KEY_W1: own_key[191:128] = cfg_data;
                    cpt_pkg::CFG_KEY_W2: own_key[127:64] = cfg_data;
                    cpt_pkg::CFG_KEY_W3: own_key[63:0] = cfg_data;
                    cpt_pkg::CFG_TIMEOUT: timeout = cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the close peer table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam longint CYCLE_LIMIT = 400000;

    logic          clk;
    logic          rst_n;
    cpt_pkg::req_t req;
    logic          req_valid;
    logic          req_stall;
    cpt_pkg::rsp_t rsp;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    logic [2:0]    cfg_index;
    logic [63:0]   cfg_data;
    logic          cfg_valid;
    logic          cfg_ready;
    int            fail_count;
    int            pending;
    int            send_idle_pct;
    int            recv_idle_pct;
    longint        cycle_count = 0;
    logic [255:0]  key_now;
    logic [255:0]  id_pool [6];
    logic [31:0]   clock_sec;

    close_peer_table_core dut (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_stall(req_stall), .rsp(rsp), .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
    );

    cpt_checker chk (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_stall(req_stall), .rsp(rsp), .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stalls at random
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_key(logic [255:0] k);
        key_now = k;
        write_reg(cpt_pkg::CFG_KEY_W0, k[255:192]);
        write_reg(cpt_pkg::CFG_KEY_W1, k[191:128]);
        write_reg(cpt_pkg::CFG_KEY_W2, k[127:64]);
        write_reg(cpt_pkg::CFG_KEY_W3, k[63:0]);
    endtask

    task automatic send(cpt_pkg::kind_t k, logic [255:0] id, logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        req.kind <= k;
        {req.peer_id_w0, req.peer_id_w1, req.peer_id_w2, req.peer_id_w3} <= id;
        req.peer_addr_hi <= rand64();
        req.peer_addr_lo <= rand64();
        req.peer_port <= 16'($urandom);
        req.now_seconds <= now;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // ids near the key so closeness compares go deep
    function automatic logic [255:0] near_key();
        logic [255:0] v;
        v = key_now;
        for (int i = 0; i < 32; i++)
            if ($urandom_range(3) == 0)
                v[8*i +: 8] = 8'(v[8*i +: 8] + $urandom_range(4) - 2);
        if ($urandom_range(3) == 0)
            v = {rand64(), rand64(), rand64(), rand64()};
        return v;
    endfunction

    task automatic random_phase(int n);
        logic [255:0] id;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                id = id_pool[$urandom_range(5)];
            else
                id = near_key();
            if ($urandom_range(9) == 0)
                id = key_now;
            id_pool[$urandom_range(5)] = id;
            clock_sec = clock_sec + $urandom_range(12);
            if ($urandom_range(19) == 0)
                clock_sec = $urandom;
            send(cpt_pkg::kind_t'($urandom_range(3)), id, clock_sec);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req = '0;
        req_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_valid = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        key_now = '0;
        clock_sec = 100;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 6; i++)
            id_pool[i] = {rand64(), rand64(), rand64(), rand64()};

        // directed: empty list, extremes, self query, evict misses and hits
        send(cpt_pkg::KIND_LIST, '0, 0);
        send(cpt_pkg::KIND_LIST, '0, 40);
        send(cpt_pkg::KIND_QUERY, '0, 40);
        send(cpt_pkg::KIND_ADD, '1, 32'hFFFF_FFFF);
        send(cpt_pkg::KIND_ADD, {8'h80, 248'h0}, 32'hFFFF_FFFF);
        send(cpt_pkg::KIND_ADD, {8'h7F, 248'h0}, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++)
            send(cpt_pkg::KIND_ADD, {rand64(), rand64(), rand64(), rand64()},
                 32'hFFFF_FFFF);
        send(cpt_pkg::KIND_ADD, 256'h1, 32'hFFFF_FFFF);
        send(cpt_pkg::KIND_ADD, 256'h2, 32'hFFFF_FFFF);
        send(cpt_pkg::KIND_ADD, '1, 32'hFFFF_FFF0);
        send(cpt_pkg::KIND_QUERY, 256'h3, 32'hFFFF_FFF0);
        send(cpt_pkg::KIND_QUERY, '1, 32'hFFFF_FFF0);
        send(cpt_pkg::KIND_LIST, '0, 32'hFFFF_FFF0);
        send(cpt_pkg::KIND_EVICT, '1, 32'hFFFF_FFF0);
        send(cpt_pkg::KIND_EVICT, 256'h5, 32'hFFFF_FFF0);
        send(cpt_pkg::KIND_LIST, '0, 32'hFFFF_FFF0);
        drain();

        write_reg(cpt_pkg::CFG_TIMEOUT, 64'd255);
        set_key({rand64(), rand64(), rand64(), rand64()});
        send_idle_pct = 28;
        recv_idle_pct = 59;
        random_phase(34);
        drain();

        write_reg(cpt_pkg::CFG_TIMEOUT, 64'd1);
        set_key('1);
        send_idle_pct = 59;
        recv_idle_pct = 28;
        random_phase(34);
        drain();

        write_reg(cpt_pkg::CFG_TIMEOUT, 64'd20);
        set_key({8'h80, 248'h7F7F});
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(34);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== close_peer_table_core.f =====
hdl/cpt_pkg.sv
hdl/close_peer_table_core.sv
bench/cpt_checker.sv
bench/tb_top.sv
